// ----- rtl/core/rmfq_pkg.sv -----
package rmfq_pkg;

  localparam int unsigned ARRAY_DEPTH = 4096;
  localparam int unsigned VALUE_RANGE = 4096;
  localparam int unsigned IDX_W       = $clog2(ARRAY_DEPTH);
  localparam int unsigned VAL_W       = $clog2(VALUE_RANGE);
  localparam int unsigned CNT_W       = $clog2(ARRAY_DEPTH + 1);
  // generation tag on count entries, a full clear runs when it wraps
  localparam int unsigned EPOCH_W     = 8;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] load_index;
    logic [VAL_W-1:0] load_value;
    logic [IDX_W-1:0] query_left;
    logic [IDX_W-1:0] query_right;
  } rmfq_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] max_frequency;
    logic             bad_range;
  } rmfq_out_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_REM = 2'd1,
    OP_NEW = 2'd2
  } op_e;

  typedef struct packed {
    logic             start;
    op_e              op;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic             ready;
    logic [CNT_W-1:0] max;
  } sts_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [CNT_W-1:0]   count;
  } entry_t;

endpackage

// ----- rtl/core/rmfq_counts.sv -----
module rmfq_counts (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rmfq_pkg::cmd_t cmd_i,
  output rmfq_pkg::sts_t sts_o
);
  import rmfq_pkg::*;

  typedef enum logic [4:0] {
    E_CLEAR = 5'b00001,
    E_IDLE  = 5'b00010,
    E_VC    = 5'b00100,
    E_OLD   = 5'b01000,
    E_NEW   = 5'b10000
  } estate_e;

  // count per value, and count of values per count (entry c-1 holds count c)
  entry_t vc_mem  [VALUE_RANGE];
  entry_t coc_mem [ARRAY_DEPTH];

  estate_e            state_q, state_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]   max_q, max_d;
  logic [VAL_W-1:0]   val_q, val_d;
  op_e                op_q, op_d;
  logic [CNT_W-1:0]   cold_q, cold_d;
  logic [CNT_W-1:0]   cnew_q, cnew_d;
  entry_t             vc_rd_q, coc_rd_q;

  logic               vc_we;
  logic [VAL_W-1:0]   vc_waddr;
  entry_t             vc_wdata;
  logic               coc_we;
  logic [IDX_W-1:0]   coc_waddr, coc_raddr;
  entry_t             coc_wdata;
  logic [CNT_W-1:0]   vc_cnt, coc_cnt, c_next;

  // entries tagged with an older epoch read as zero
  assign vc_cnt  = (vc_rd_q.tag == epoch_q) ? vc_rd_q.count : '0;
  assign coc_cnt = (coc_rd_q.tag == epoch_q) ? coc_rd_q.count : '0;
  assign c_next  = (op_q == OP_ADD) ? vc_cnt + CNT_W'(1) : vc_cnt - CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    epoch_d   = epoch_q;
    clr_d     = clr_q;
    max_d     = max_q;
    val_d     = val_q;
    op_d      = op_q;
    cold_d    = cold_q;
    cnew_d    = cnew_q;
    vc_we     = 1'b0;
    vc_waddr  = val_q;
    vc_wdata  = '{tag: epoch_q, count: c_next};
    coc_we    = 1'b0;
    coc_waddr = IDX_W'(cold_q - CNT_W'(1));
    coc_wdata = '0;
    coc_raddr = '0;
    case (state_q)
      E_CLEAR: begin
        vc_we     = 1'b1;
        vc_waddr  = VAL_W'(clr_q);
        vc_wdata  = '0;
        coc_we    = 1'b1;
        coc_waddr = clr_q;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(ARRAY_DEPTH - 1)) begin
          state_d = E_IDLE;
        end
      end
      E_IDLE: begin
        if (cmd_i.start) begin
          case (cmd_i.op)
            OP_NEW: begin
              max_d = '0;
              if (epoch_q == {EPOCH_W{1'b1}}) begin
                epoch_d = '0;
                clr_d   = '0;
                state_d = E_CLEAR;
              end else begin
                epoch_d = epoch_q + EPOCH_W'(1);
              end
            end
            OP_ADD, OP_REM: begin
              val_d   = cmd_i.value;
              op_d    = cmd_i.op;
              state_d = E_VC;
            end
            default: ;
          endcase
        end
      end
      E_VC: begin
        cold_d    = vc_cnt;
        cnew_d    = c_next;
        coc_raddr = (vc_cnt != '0) ? IDX_W'(vc_cnt - CNT_W'(1)) : '0;
        if (op_q == OP_REM && vc_cnt == '0) begin
          state_d = E_IDLE;
        end else begin
          vc_we   = 1'b1;
          state_d = (vc_cnt != '0) ? E_OLD : E_NEW;
        end
      end
      E_OLD: begin
        // new count's entry is read while the old count's entry is written
        coc_raddr = IDX_W'(cnew_q - CNT_W'(1));
        if (coc_cnt != '0) begin
          coc_we    = 1'b1;
          coc_wdata = '{tag: epoch_q, count: coc_cnt - CNT_W'(1)};
        end
        if (op_q == OP_REM && cold_q == max_q && coc_cnt <= CNT_W'(1)) begin
          max_d = max_q - CNT_W'(1);
        end
        state_d = (cnew_q != '0) ? E_NEW : E_IDLE;
      end
      E_NEW: begin
        coc_we    = 1'b1;
        coc_waddr = IDX_W'(cnew_q - CNT_W'(1));
        coc_wdata = '{tag: epoch_q, count: coc_cnt + CNT_W'(1)};
        if (op_q == OP_ADD && cnew_q > max_q) begin
          max_d = cnew_q;
        end
        state_d = E_IDLE;
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_CLEAR;
      epoch_q <= '0;
      clr_q   <= '0;
      max_q   <= '0;
    end else begin
      state_q <= state_d;
      epoch_q <= epoch_d;
      clr_q   <= clr_d;
      max_q   <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    op_q   <= op_d;
    cold_q <= cold_d;
    cnew_q <= cnew_d;
  end

  always_ff @(posedge clk_i) begin
    if (vc_we) begin
      vc_mem[vc_waddr] <= vc_wdata;
    end
    vc_rd_q <= vc_mem[cmd_i.value];
  end

  always_ff @(posedge clk_i) begin
    if (coc_we) begin
      coc_mem[coc_waddr] <= coc_wdata;
    end
    coc_rd_q <= coc_mem[coc_raddr];
  end

  assign sts_o.ready = (state_q == E_IDLE);
  assign sts_o.max   = max_q;

endmodule

// ----- rtl/core/range_max_frequency_query_unit.sv -----
// channel | signals                                | payload
// --------+----------------------------------------+---------------------------------
// in      | in_valid_i / in_ready_o / in_data_i    | action, load index/value, window
// out     | out_valid_o / out_ready_i / out_data_o | max_frequency, bad_range
//
// a load writes the element store and returns nothing; a reversed window skips the walk and
//   answers with bad_range set once the output register is free
// a query walks each element added or removed: an element read, then a read-modify-write
//   of the value count and of the count-of-count entries of the old and new counts; each
//   edge segment is planned first, and a rebuilt window first starts a new count epoch
// after reset, and on every 256th rebuild, a clearing pass runs over the count memories;
//   no item is taken meanwhile
// a result waiting in the output register stalls only the completion of the next query
module range_max_frequency_query_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rmfq_pkg::rmfq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rmfq_pkg::rmfq_out_t out_data_o
);
  import rmfq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLR    = 8'b0000_0010,
    S_CLRW   = 8'b0000_0100,
    S_PLAN   = 8'b0000_1000,
    S_FETCH  = 8'b0001_0000,
    S_UPDATE = 8'b0010_0000,
    S_WAIT   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  // edge segments walked in order: grow left, grow right, shrink left, shrink right
  localparam logic [1:0] SEG_GROW_L   = 2'd0;
  localparam logic [1:0] SEG_GROW_R   = 2'd1;
  localparam logic [1:0] SEG_SHRINK_L = 2'd2;
  localparam logic [1:0] SEG_SHRINK_R = 2'd3;

  logic [VAL_W-1:0] es_mem [ARRAY_DEPTH];
  logic [VAL_W-1:0] es_rd_q;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] ws_q, ws_d, we_q, we_d;
  logic             wv_q, wv_d;
  logic             out_valid_q, out_valid_d;
  rmfq_out_t        out_q, out_d;
  logic [IDX_W-1:0] ql_q, ql_d, qr_q, qr_d;
  logic             rebuild_q, rebuild_d;
  logic             bad_q, bad_d;
  logic [1:0]       seg_q, seg_d;
  logic [IDX_W-1:0] pos_q, pos_d, end_q, end_d;
  op_e              op_q, op_d;

  logic             seg_vld;
  logic [IDX_W-1:0] seg_lo, seg_hi;
  op_e              seg_op;
  logic             in_xfer;
  cmd_t             eng_cmd;
  sts_t             eng_sts;

  rmfq_counts u_counts (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (eng_cmd),
    .sts_o  (eng_sts)
  );

  assign in_ready_o = (state_q == S_IDLE) && eng_sts.ready;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    seg_vld = 1'b0;
    seg_lo  = ql_q;
    seg_hi  = qr_q;
    seg_op  = OP_ADD;
    case (seg_q)
      SEG_GROW_L: begin
        if (rebuild_q) begin
          seg_vld = 1'b1;
        end else begin
          seg_vld = ql_q < ws_q;
          seg_hi  = ws_q - IDX_W'(1);
        end
      end
      SEG_GROW_R: begin
        seg_vld = !rebuild_q && (qr_q > we_q);
        seg_lo  = we_q + IDX_W'(1);
      end
      SEG_SHRINK_L: begin
        seg_vld = !rebuild_q && (ws_q < ql_q);
        seg_lo  = ws_q;
        seg_hi  = ql_q - IDX_W'(1);
        seg_op  = OP_REM;
      end
      SEG_SHRINK_R: begin
        seg_vld = !rebuild_q && (qr_q < we_q);
        seg_lo  = qr_q + IDX_W'(1);
        seg_hi  = we_q;
        seg_op  = OP_REM;
      end
      default: ;
    endcase
  end

  always_comb begin
    logic finish;
    finish        = 1'b0;
    state_d       = state_q;
    ws_d          = ws_q;
    we_d          = we_q;
    wv_d          = wv_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;
    ql_d          = ql_q;
    qr_d          = qr_q;
    rebuild_d     = rebuild_q;
    bad_d         = bad_q;
    seg_d         = seg_q;
    pos_d         = pos_q;
    end_d         = end_q;
    op_d          = op_q;
    eng_cmd.start = 1'b0;
    eng_cmd.op    = op_q;
    eng_cmd.value = es_rd_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.action == ACT_LOAD) begin
            wv_d = 1'b0;
          end else begin
            ql_d  = in_data_i.query_left;
            qr_d  = in_data_i.query_right;
            seg_d = SEG_GROW_L;
            if (in_data_i.query_left > in_data_i.query_right) begin
              bad_d   = 1'b1;
              state_d = S_DONE;
            end else begin
              bad_d     = 1'b0;
              rebuild_d = !wv_q || (in_data_i.query_left > we_q) ||
                          (in_data_i.query_right < ws_q);
              state_d   = rebuild_d ? S_CLR : S_PLAN;
            end
          end
        end
      end
      S_CLR: begin
        eng_cmd.start = 1'b1;
        eng_cmd.op    = OP_NEW;
        state_d       = S_CLRW;
      end
      S_CLRW: begin
        if (eng_sts.ready) begin
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        if (seg_vld) begin
          pos_d   = seg_lo;
          end_d   = seg_hi;
          op_d    = seg_op;
          state_d = S_FETCH;
        end else if (seg_q == SEG_SHRINK_R) begin
          finish = 1'b1;
        end else begin
          seg_d = seg_q + 2'd1;
        end
      end
      S_FETCH: state_d = S_UPDATE;
      S_UPDATE: begin
        eng_cmd.start = 1'b1;
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (eng_sts.ready) begin
          if (pos_q != end_q) begin
            pos_d   = pos_q + IDX_W'(1);
            state_d = S_FETCH;
          end else if (seg_q == SEG_SHRINK_R) begin
            finish = 1'b1;
          end else begin
            seg_d   = seg_q + 2'd1;
            state_d = S_PLAN;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.max_frequency = bad_q ? '0 : eng_sts.max;
          out_d.bad_range     = bad_q;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (finish) begin
      ws_d    = ql_q;
      we_d    = qr_q;
      wv_d    = 1'b1;
      state_d = S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ws_q        <= '0;
      we_q        <= '0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      we_q        <= we_d;
      wv_q        <= wv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    ql_q      <= ql_d;
    qr_q      <= qr_d;
    rebuild_q <= rebuild_d;
    bad_q     <= bad_d;
    seg_q     <= seg_d;
    pos_q     <= pos_d;
    end_q     <= end_d;
    op_q      <= op_d;
  end

  // element store, one write port for loads, one registered read for the walk
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.action == ACT_LOAD) begin
      es_mem[in_data_i.load_index] <= in_data_i.load_value;
    end
    es_rd_q <= es_mem[pos_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_range |-> out_data_o.max_frequency == '0)
    else $error("reversed window returned a nonzero frequency");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> ws_q <= we_q)
    else $error("held window has start beyond end");

  a_load_drops_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.action == ACT_LOAD |=> !wv_q)
    else $error("window still held after a load transfer");

  a_walk_engine_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> eng_sts.ready)
    else $error("element fetched while count update still running");
`endif

endmodule
